>>> src/soft_uart_half_duplex_top_macros.svh
// Assertion macros used by the UART transceiver top level.
`ifndef SOFT_UART_HALF_DUPLEX_TOP_MACROS_SVH
`define SOFT_UART_HALF_DUPLEX_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUHD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SUHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/suhd_pkg.sv
// Package with the types, codes and widths of the half-duplex UART transceiver.
package suhd_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int DATA_BITS   = 8;
    localparam int IDX_WIDTH   = 4;

    localparam logic [COUNT_WIDTH-1:0] PERIOD_RESET = 24'd7488;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_TX   = 2'd1;
    localparam logic [1:0] KIND_RX   = 2'd2;

    // Operating modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;
    localparam logic [1:0] MODE_RX   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] ADDR_BIT_PERIOD = 3'd0;

    typedef struct packed {
        logic [1:0]           kind;
        logic [DATA_BITS-1:0] tx_byte;
        logic                 rx_level;
    } t_item;

    typedef struct packed {
        logic                 cmd_ignored;
        logic                 rx_error;
        logic [DATA_BITS-1:0] rx_byte;
        logic                 rx_done;
        logic                 tx_done;
        logic [1:0]           mode_now;
        logic                 tx_pin;
    } t_result;

endpackage

>>> src/soft_uart_half_duplex_top.sv
// Top level of the half-duplex 8N1 UART transceiver with its stream and APB ports.
//
// Usage: every request on the slave stream is either one clock tick of the bit
// timer (carrying the sampled receive line level), a start-transmit command with
// the byte to send, an arm-receive command or, with the unused kind code, a no-op;
// the kind travels on tuser. Every request yields exactly one response on the
// master stream with the transmit pin level, the mode, the done and error pulses,
// the receive shift register and a flag for commands that arrived while busy.
// The bit period is written through the APB port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// A request is captured in an input register, the state update runs in one
// combinational pass and the response is captured in an output register.
// Throughput is one request per cycle while the response side does not stall;
// the limit is the single state update. The input side keeps taking requests
// while a response waits, until both registers hold data. If the response side
// stalls, the response holds and the state is not advanced, so no request is lost
// or repeated. Reset (synchronous, active low) returns the transceiver to idle
// with the pin low, clears both registers and sets the bit period to 7488 ticks.
`include "soft_uart_half_duplex_top_macros.svh"
module soft_uart_half_duplex_top
    import suhd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [7:0] tx_byte, [8] rx_level, [15:9] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] kind
    // Master stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] tx_pin, [2:1] mode_now, [3] tx_done, [4] rx_done, [12:5] rx_byte,
    // [13] rx_error, [14] cmd_ignored, [15] zero
    output logic [15:0] o_m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                   r_in_valid;
    t_item                  r_in_item;
    logic                   r_out_valid;
    t_result                r_out_res;
    logic [COUNT_WIDTH-1:0] r_bit_period;

    logic    in_take;
    logic    adv;
    t_result n_res;

    // The state advances whenever a held request can move into the output register.
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.kind     <= i_s_tuser;
            r_in_item.tx_byte  <= i_s_tdata[7:0];
            r_in_item.rx_level <= i_s_tdata[8];
        end
    end

    suhd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_item       (r_in_item),
        .i_bit_period (r_bit_period),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_res};

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= PERIOD_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_BIT_PERIOD)) begin
            r_bit_period <= pwdata[COUNT_WIDTH-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_BIT_PERIOD: prdata = {{(32 - COUNT_WIDTH){1'b0}}, r_bit_period};
            default:         prdata = '0;
        endcase
    end

    // A taken request must be held in the input register.
    `SUHD_ASSERT_NEXT(a_in_held, in_take, r_in_valid, "request taken but not held")
    // A state update must leave a response on the master side.
    `SUHD_ASSERT_NEXT(a_out_after_adv, adv, o_m_tvalid, "state advanced without a response")
    // A finished frame always leaves the transceiver idle.
    `SUHD_ASSERT_SAME(a_done_idle, o_m_tvalid && (r_out_res.tx_done || r_out_res.rx_done),
        r_out_res.mode_now == MODE_IDLE, "frame done while not idle")
    // A receive error and a receive completion never come together.
    `SUHD_ASSERT_SAME(a_rx_flags, o_m_tvalid, !(r_out_res.rx_done && r_out_res.rx_error),
        "receive done and error in one response")

endmodule

>>> src/suhd_core.sv
// Transceiver state registers and the single-pass update for one request.
module suhd_core
    import suhd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_item                  i_item,
    input  logic [COUNT_WIDTH-1:0] i_bit_period,
    output t_result                o_res
);

    localparam logic [IDX_WIDTH-1:0] LAST_DATA_IDX = IDX_WIDTH'(DATA_BITS);
    localparam logic [IDX_WIDTH-1:0] STOP_IDX      = IDX_WIDTH'(DATA_BITS + 1);

    logic [1:0]             r_mode, n_mode;
    logic [IDX_WIDTH-1:0]   r_idx, n_idx;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [DATA_BITS-1:0]   r_tx_shift, n_tx_shift;
    logic [DATA_BITS-1:0]   r_rx_shift, n_rx_shift;
    logic                   r_tx_drive, n_tx_drive;

    logic                   tmr_ev;
    logic [COUNT_WIDTH-1:0] tmr_next;
    logic [COUNT_WIDTH-1:0] half_period;
    logic [IDX_WIDTH-1:0]   idx_inc;
    logic                   tx_done, rx_done, rx_error, cmd_ignored;

    // Bit timer: reloads the full period when it runs down to one or less.
    assign tmr_ev      = (r_cnt <= COUNT_WIDTH'(1));
    assign tmr_next    = tmr_ev ? i_bit_period : r_cnt - COUNT_WIDTH'(1);
    assign half_period = (i_bit_period[COUNT_WIDTH-1:1] == '0) ? COUNT_WIDTH'(1)
                         : {1'b0, i_bit_period[COUNT_WIDTH-1:1]};
    assign idx_inc     = r_idx + IDX_WIDTH'(1);

    always_comb begin
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_tx_shift  = r_tx_shift;
        n_rx_shift  = r_rx_shift;
        n_tx_drive  = r_tx_drive;
        tx_done     = 1'b0;
        rx_done     = 1'b0;
        rx_error    = 1'b0;
        cmd_ignored = 1'b0;
        case (i_item.kind)
            KIND_TX, KIND_RX: begin
                if (r_mode != MODE_IDLE) begin
                    cmd_ignored = 1'b1;
                end else if (i_item.kind == KIND_TX) begin
                    n_tx_shift = i_item.tx_byte;
                    n_tx_drive = 1'b1;
                    n_idx      = '0;
                    n_cnt      = i_bit_period;
                    n_mode     = MODE_TX;
                end else begin
                    n_idx  = '0;
                    n_mode = MODE_WAIT;
                end
            end
            KIND_TICK: begin
                unique case (r_mode)
                    MODE_TX: begin
                        n_cnt = tmr_next;
                        if (tmr_ev) begin
                            n_idx = idx_inc;
                            if (idx_inc <= LAST_DATA_IDX) begin
                                // Inverted pin: a zero data bit drives high.
                                n_tx_drive = ~r_tx_shift[0];
                                n_tx_shift = r_tx_shift >> 1;
                            end else if (idx_inc == STOP_IDX) begin
                                n_tx_drive = 1'b0;
                            end else begin
                                n_idx   = '0;
                                n_mode  = MODE_IDLE;
                                tx_done = 1'b1;
                            end
                        end
                    end
                    MODE_WAIT: begin
                        if (!i_item.rx_level) begin
                            n_cnt  = half_period;
                            n_idx  = '0;
                            n_mode = MODE_RX;
                        end
                    end
                    MODE_RX: begin
                        n_cnt = tmr_next;
                        if (tmr_ev) begin
                            if (r_idx == '0) begin
                                if (!i_item.rx_level) begin
                                    n_rx_shift = '0;
                                    n_idx      = IDX_WIDTH'(1);
                                end else begin
                                    n_mode   = MODE_IDLE;
                                    rx_error = 1'b1;
                                end
                            end else if (r_idx <= LAST_DATA_IDX) begin
                                n_rx_shift = {i_item.rx_level, r_rx_shift[DATA_BITS-1:1]};
                                n_idx      = idx_inc;
                            end else begin
                                n_idx    = '0;
                                n_mode   = MODE_IDLE;
                                rx_done  = i_item.rx_level;
                                rx_error = ~i_item.rx_level;
                            end
                        end
                    end
                    default: begin
                        // Ticks while idle change nothing.
                    end
                endcase
            end
            default: begin
                // The unused kind code is a no-operation.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_tx_shift <= '0;
            r_rx_shift <= '0;
            r_tx_drive <= 1'b0;
        end else if (i_en) begin
            r_mode     <= n_mode;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
            r_tx_shift <= n_tx_shift;
            r_rx_shift <= n_rx_shift;
            r_tx_drive <= n_tx_drive;
        end
    end

    always_comb begin
        o_res.tx_pin      = n_tx_drive;
        o_res.mode_now    = n_mode;
        o_res.tx_done     = tx_done;
        o_res.rx_done     = rx_done;
        o_res.rx_byte     = n_rx_shift;
        o_res.rx_error    = rx_error;
        o_res.cmd_ignored = cmd_ignored;
    end

endmodule

>>> test/tb.sv
// Self-checking testbench for the half-duplex 8N1 UART transceiver top level.
module tb;
    import suhd_pkg::*;

    // The stream carries a fourth request kind that the transceiver treats as a no-op.
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Cycles without any stream handshake before the run is declared hung.
    localparam int IDLE_LIMIT      = 4000;
    // Requests in total that the run aims for; the random part fills up to it.
    localparam int ITEM_TARGET     = 1850;
    // Length of the long response-side hold-off.
    localparam int HOLD_OFF_CYCLES = 300;

    // Ways in which the response side stalls.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_style;

    // Clock, reset and every input of the block start at known values.
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = 16'd0;
    logic [1:0]  s_tuser  = KIND_TICK;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = ADDR_BIT_PERIOD;
    logic [31:0] pwdata   = 32'd0;

    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [31:0] prdata;
    logic        pready;

    soft_uart_half_duplex_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] tx_byte, [8] rx_level, [15:9] zero
        .i_s_tuser  (s_tuser),   // [1:0] kind
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        // [0] tx_pin, [2:1] mode_now, [3] tx_done, [4] rx_done, [12:5] rx_byte,
        // [13] rx_error, [14] cmd_ignored, [15] zero
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Twenty time units per cycle, rising edges at 10, 30, 50 and so on.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the transceiver state. It advances once per accepted request,
    // in acceptance order, so the stimulus code can also steer by it.
    logic [1:0]             uart_mode;
    logic [IDX_WIDTH-1:0]   uart_bit_idx;
    logic [COUNT_WIDTH-1:0] uart_timer;
    logic [DATA_BITS-1:0]   uart_tx_shift;
    logic [DATA_BITS-1:0]   uart_rx_shift;
    logic                   uart_pin;
    logic [COUNT_WIDTH-1:0] uart_period;

    // Responses predicted for accepted requests, oldest first.
    t_result pending_responses[$];

    int errors         = 0;
    int items_sent     = 0;
    int work_items     = 0;
    int responses_seen = 0;
    int tx_frames      = 0;
    int rx_frames      = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    int cmd_noise_pct  = 0;
    int quiet_cycles   = 0;

    // The test side bumps hold_req; the response side acknowledges it and holds off.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    t_ready_style ready_style = READY_ALWAYS;
    int           style_left  = 0;
    int           stall_phase = 0;

    // One tick of the bit timer. A count of one or less reloads the full period and
    // marks a bit event, which also makes periods of zero and one fire on every tick.
    function automatic bit bit_timer_tick();
        if (uart_timer <= 1) begin
            uart_timer = uart_period;
            return 1'b1;
        end
        uart_timer = uart_timer - 1'b1;
        return 1'b0;
    endfunction

    // Next transceiver state and the response for one request.
    function automatic t_result uart_step(input t_item req);
        t_result                rsp;
        logic [COUNT_WIDTH-1:0] half;
        rsp = '0;
        if (req.kind == KIND_TX || req.kind == KIND_RX) begin
            // A command only acts from idle; otherwise it is flagged and dropped.
            if (uart_mode != MODE_IDLE) begin
                rsp.cmd_ignored = 1'b1;
            end else if (req.kind == KIND_TX) begin
                uart_tx_shift = req.tx_byte;
                uart_pin      = 1'b1;
                uart_bit_idx  = '0;
                uart_timer    = uart_period;
                uart_mode     = MODE_TX;
            end else begin
                uart_bit_idx = '0;
                uart_mode    = MODE_WAIT;
            end
        end else if (req.kind == KIND_TICK) begin
            case (uart_mode)
                MODE_TX: begin
                    if (bit_timer_tick()) begin
                        uart_bit_idx = uart_bit_idx + 1'b1;
                        if (uart_bit_idx <= DATA_BITS) begin
                            // The pin is inverted: a zero data bit drives it high.
                            uart_pin      = ~uart_tx_shift[0];
                            uart_tx_shift = uart_tx_shift >> 1;
                        end else if (uart_bit_idx == DATA_BITS + 1) begin
                            uart_pin = 1'b0;
                        end else begin
                            uart_bit_idx = '0;
                            uart_mode    = MODE_IDLE;
                            rsp.tx_done  = 1'b1;
                        end
                    end
                end
                MODE_WAIT: begin
                    // The falling edge starts the half-period wait to mid start bit.
                    if (!req.rx_level) begin
                        half         = uart_period >> 1;
                        uart_timer   = (half != '0) ? half : COUNT_WIDTH'(1);
                        uart_bit_idx = '0;
                        uart_mode    = MODE_RX;
                    end
                end
                MODE_RX: begin
                    if (bit_timer_tick()) begin
                        if (uart_bit_idx == 0) begin
                            if (!req.rx_level) begin
                                uart_rx_shift = '0;
                                uart_bit_idx  = IDX_WIDTH'(1);
                            end else begin
                                uart_mode    = MODE_IDLE;
                                rsp.rx_error = 1'b1;
                            end
                        end else if (uart_bit_idx <= DATA_BITS) begin
                            uart_rx_shift = {req.rx_level, uart_rx_shift[DATA_BITS-1:1]};
                            uart_bit_idx  = uart_bit_idx + 1'b1;
                        end else begin
                            uart_bit_idx = '0;
                            uart_mode    = MODE_IDLE;
                            if (req.rx_level) begin
                                rsp.rx_done = 1'b1;
                            end else begin
                                rsp.rx_error = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        rsp.tx_pin   = uart_pin;
        rsp.mode_now = uart_mode;
        rsp.rx_byte  = uart_rx_shift;
        return rsp;
    endfunction

    // Offers one request and returns right after the edge at which it is taken.
    // The sender runs in bursts; between bursts tvalid drops for a random gap.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] data, input logic level);
        t_item req;
        int    gap;
        req.kind     = kind;
        req.tx_byte  = data;
        req.rx_level = level;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {7'd0, req.rx_level, req.tx_byte};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        // Idle ticks, no-ops and busy commands leave the transceiver as it was.
        if (kind == KIND_TICK ? (uart_mode != MODE_IDLE)
                              : ((kind == KIND_TX || kind == KIND_RX) && uart_mode == MODE_IDLE))
            work_items++;
        pending_responses.push_back(uart_step(req));
        items_sent++;
        burst_left--;
    endtask

    // Stops offering requests and waits until every predicted response has come.
    task automatic drain_responses();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Reads the bit period back over APB and compares it with the shadow copy.
    task automatic check_bit_period();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BIT_PERIOD;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(32 - COUNT_WIDTH){1'b0}}, uart_period}) begin
            $display("%0t: bit_period read expected %h actual %h",
                     $time, {{(32 - COUNT_WIDTH){1'b0}}, uart_period}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes the bit period (only the low COUNT_WIDTH bits are kept) and reads it back.
    task automatic set_bit_period(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BIT_PERIOD;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        uart_period = value[COUNT_WIDTH-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        settings_used++;
        check_bit_period();
    endtask

    // One tick with the given line level. While the transceiver is busy a stray
    // command or no-op is sometimes slipped in first; it must not move the timer.
    task automatic line_tick(input logic level);
        if (uart_mode != MODE_IDLE && $urandom_range(0, 99) < cmd_noise_pct)
            send_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
        send_item(KIND_TICK, 8'($urandom), level);
    endtask

    // Ticks until the transceiver is idle again; a waiting receiver gets its edge.
    task automatic settle_to_idle();
        while (uart_mode != MODE_IDLE)
            line_tick((uart_mode == MODE_WAIT) ? 1'b0 : 1'b1);
        repeat ($urandom_range(0, 3)) send_item(KIND_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic tx_frame(input logic [7:0] data);
        send_item(KIND_TX, data, 1'($urandom));
        while (uart_mode != MODE_IDLE) line_tick(1'($urandom));
        settle_to_idle();
        tx_frames++;
    endtask

    // Drives one serial frame on the receive line, each bit one period wide. With a
    // period below two every tick is a bit event, so the start bit takes two ticks:
    // the edge itself and the start sample. A false start is a one-tick glitch.
    task automatic rx_frame(input logic [7:0] data, input logic stop_level, input bit false_start);
        logic [9:0] frame_bits;
        int         bit_len;
        frame_bits = {stop_level, data, 1'b0};
        send_item(KIND_RX, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 4)) line_tick(1'b1);
        if (false_start) begin
            line_tick(1'b0);
        end else begin
            for (int k = 0; k < 10; k++) begin
                bit_len = (uart_period < 2) ? ((k == 0) ? 2 : 1) : int'(uart_period);
                repeat (bit_len) line_tick(frame_bits[k]);
            end
        end
        settle_to_idle();
        rx_frames++;
    endtask

    // Requests of any kind with random content, then back to idle.
    task automatic noise_burst();
        repeat ($urandom_range(4, 24))
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        settle_to_idle();
    endtask

    // Reset value of the period, ticks while idle and no-ops at both field extremes.
    task automatic test_reset_idle();
        check_bit_period();
        send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_TICK, 8'hFF, 1'b1);
        send_item(KIND_NONE, 8'hFF, 1'b1);
        send_item(KIND_NONE, 8'h00, 1'b0);
        drain_responses();
    endtask

    // A period of one: every tick is a bit event. A busy arm-receive and a no-op
    // in the middle of the frame must not shift its timing.
    task automatic test_tiny_period_tx();
        set_bit_period(32'd1);
        send_item(KIND_TX, 8'hFF, 1'b0);
        send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_RX, 8'h00, 1'b0);
        send_item(KIND_NONE, 8'h5A, 1'b1);
        while (uart_mode != MODE_IDLE) send_item(KIND_TICK, 8'h00, 1'b1);
        drain_responses();
    endtask

    // A period of zero: the half period before the start sample is one tick.
    // A transmit command while waiting for the edge is ignored.
    task automatic test_zero_period_rx();
        set_bit_period(32'd0);
        cmd_noise_pct = 0;
        send_item(KIND_RX, 8'h00, 1'b1);
        send_item(KIND_TICK, 8'h00, 1'b1);
        send_item(KIND_TX, 8'hFF, 1'b0);
        rx_frame(8'h00, 1'b1, 1'b0);
        drain_responses();
    endtask

    // Mostly well-formed frames at small periods, with bad stop bits, false starts,
    // stray commands and noise mixed in. Now and then the upper, unused write bits
    // are set to show that they are dropped.
    task automatic test_random_traffic();
        int          pick;
        logic [23:0] period;
        logic [7:0]  upper;
        cmd_noise_pct = 5;
        while (items_sent < ITEM_TARGET) begin
            drain_responses();
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                period = 24'($urandom_range(2, 6));
            end else if (pick < 9) begin
                period = 24'($urandom_range(7, 24));
            end else begin
                period = 24'd2;
            end
            upper = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
            set_bit_period({upper, period});
            repeat ($urandom_range(3, 6)) begin
                if (items_sent < ITEM_TARGET) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 8) begin
                        tx_frame(8'($urandom));
                    end else if (pick < 15) begin
                        rx_frame(8'($urandom), 1'b1, 1'b0);
                    end else if (pick < 17) begin
                        rx_frame(8'($urandom), 1'b0, 1'b0);
                    end else if (pick < 18) begin
                        rx_frame(8'($urandom), 1'b1, 1'b1);
                    end else begin
                        noise_burst();
                    end
                end
            end
        end
        drain_responses();
    endtask

    // The response side holds off for a long stretch while the sender keeps
    // offering, so both internal registers fill and the request side stalls.
    task automatic test_backpressure();
        set_bit_period(32'd2);
        burst_left = 1000;
        hold_req++;
        tx_frame(8'($urandom));
        rx_frame(8'($urandom), 1'b1, 1'b0);
        drain_responses();
    endtask

    // One frame each way at a longer period exercises the wider counter bits.
    task automatic test_long_period();
        set_bit_period(32'd40);
        tx_frame(8'($urandom));
        rx_frame(8'($urandom), 1'b1, 1'b0);
        drain_responses();
    endtask

    // The largest period, written with every data bit set; only idle traffic
    // follows since a frame would run for millions of ticks.
    task automatic test_max_period();
        set_bit_period(32'hFFFF_FFFF);
        repeat (5) send_item(KIND_TICK, 8'($urandom), 1'($urandom));
        repeat (3) send_item(KIND_NONE, 8'($urandom), 1'($urandom));
        drain_responses();
    endtask

    // Response side: a long hold-off when the test asks for one, otherwise a
    // stall style that is picked anew at random whenever its run ends.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (style_left <= 0) begin
                ready_style = t_ready_style'($urandom_range(0, 3));
                style_left  = $urandom_range(20, 120);
            end
            style_left--;
            stall_phase++;
            case (ready_style)
                READY_ALWAYS:   m_tready <= 1'b1;
                READY_COIN:     m_tready <= 1'($urandom);
                READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                default:        m_tready <= ((stall_phase % 5) != 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Every response taken from the block is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[14:0];
            responses_seen++;
            if (pending_responses.size() == 0) begin
                $display("%0t: response %h arrived with none expected", $time, m_tdata);
                errors++;
            end else begin
                want = pending_responses.pop_front();
                check_field("tx_pin", 8'(want.tx_pin), 8'(got.tx_pin));
                check_field("mode_now", 8'(want.mode_now), 8'(got.mode_now));
                check_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
                check_field("rx_done", 8'(want.rx_done), 8'(got.rx_done));
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("rx_error", 8'(want.rx_error), 8'(got.rx_error));
                check_field("cmd_ignored", 8'(want.cmd_ignored), 8'(got.cmd_ignored));
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either stream means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        // The shadow state starts where reset leaves the block.
        uart_mode     = MODE_IDLE;
        uart_bit_idx  = '0;
        uart_timer    = '0;
        uart_tx_shift = '0;
        uart_rx_shift = '0;
        uart_pin      = 1'b0;
        uart_period   = PERIOD_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_idle();
        test_tiny_period_tx();
        test_zero_period_rx();
        test_backpressure();
        test_long_period();
        test_random_traffic();
        test_max_period();

        drain_responses();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d requests (%0d changing state) across %0d bit-period settings.",
                 items_sent, work_items, settings_used);
        $display("Sent %0d transmit and %0d receive frames; checked %0d responses.",
                 tx_frames, rx_frames, responses_seen);
        if (errors == 0 && pending_responses.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
